[src/circumcircle_of_three_points_unit_defines.svh]
// Assertion macros for the circumcircle unit.
// Depends on nothing; users supply aclk and aresetn in scope.
`ifndef CIRCUMCIRCLE_OF_THREE_POINTS_UNIT_DEFINES_SVH
`define CIRCUMCIRCLE_OF_THREE_POINTS_UNIT_DEFINES_SVH

// same-cycle implication
`define CC3P_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CC3P_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cc3p_pkg.sv]
// Shared widths, status codes and sideband types of the circumcircle unit.
// Depends on nothing.
package cc3p_pkg;

    localparam int CW          = 16;
    localparam int DW          = 17;
    localparam int SQW         = 34;
    localparam int PW          = 35;
    localparam int MW          = 52;
    localparam int NW          = 53;
    localparam int FRAC        = 8;
    localparam int DIVN_W      = 60;
    localparam int DIVD_W      = 36;
    localparam int DIV_STAGES  = DIVN_W;
    localparam int OW          = 64;
    localparam int RW          = 32;
    localparam int SQ_IN_W     = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 34;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int POST_STAGES = 5;
    localparam int FRONT_STAGES = 6;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_COLINEAR = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } pts_t;

    typedef struct packed {
        pts_t pts;
        logic neg_x;
        logic neg_y;
        logic colin;
    } div_side_t;

    typedef struct packed {
        logic [RW-1:0] rx;
        logic [RW-1:0] ry;
        logic          sat;
        logic          colin;
    } res_side_t;

endpackage

[src/cc3p_front.sv]
// Front pipeline: differences, squares, cross product, numerators, divider operands.
// Depends on cc3p_pkg.
module cc3p_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [cc3p_pkg::CW-1:0] a_x,
    input  logic signed [cc3p_pkg::CW-1:0] a_y,
    input  logic signed [cc3p_pkg::CW-1:0] b_x,
    input  logic signed [cc3p_pkg::CW-1:0] b_y,
    input  logic signed [cc3p_pkg::CW-1:0] c_x,
    input  logic signed [cc3p_pkg::CW-1:0] c_y,
    output logic                          out_valid,
    output logic [cc3p_pkg::DIVN_W-1:0]    num_x,
    output logic [cc3p_pkg::DIVN_W-1:0]    num_y,
    output logic [cc3p_pkg::DIVD_W-1:0]    den2,
    output cc3p_pkg::div_side_t           side
);
    import cc3p_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;

    logic signed [DW-1:0]  xb1_reg, yb1_reg, xc1_reg, yc1_reg;
    logic signed [DW-1:0]  xb1_next, yb1_next, xc1_next, yc1_next;
    pts_t                  pts1_reg, pts2_reg, pts3_reg, pts4_reg, pts5_reg;

    logic signed [SQW-1:0] pxx_reg, pyy_reg, qxx_reg, qyy_reg, pd1_reg, pd2_reg;
    logic signed [SQW-1:0] pxx_next, pyy_next, qxx_next, qyy_next, pd1_next, pd2_next;
    logic signed [DW-1:0]  xb2_reg, yb2_reg, xc2_reg, yc2_reg;

    logic signed [PW-1:0]  qb_reg, qc_reg, dd3_reg, qb_next, qc_next, dd3_next;
    logic signed [DW-1:0]  xb3_reg, yb3_reg, xc3_reg, yc3_reg;

    logic signed [MW-1:0]  m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [MW-1:0]  m1_next, m2_next, m3_next, m4_next;
    logic signed [PW-1:0]  dd4_reg, dd5_reg;

    logic signed [NW-1:0]  nx_reg, ny_reg, nx_next, ny_next;

    logic [NW-1:0]         abs_nx, abs_ny;
    logic [PW-1:0]         abs_d;
    logic [DIVN_W-1:0]     numx_reg, numy_reg, numx_next, numy_next;
    logic [DIVD_W-1:0]     den2_reg, den2_next;
    div_side_t             side_reg, side_next;

    always_comb begin
        xb1_next = DW'(b_x) - DW'(a_x);
        yb1_next = DW'(b_y) - DW'(a_y);
        xc1_next = DW'(c_x) - DW'(a_x);
        yc1_next = DW'(c_y) - DW'(a_y);

        pxx_next = SQW'(xb1_reg) * SQW'(xb1_reg);
        pyy_next = SQW'(yb1_reg) * SQW'(yb1_reg);
        qxx_next = SQW'(xc1_reg) * SQW'(xc1_reg);
        qyy_next = SQW'(yc1_reg) * SQW'(yc1_reg);
        pd1_next = SQW'(xb1_reg) * SQW'(yc1_reg);
        pd2_next = SQW'(xc1_reg) * SQW'(yb1_reg);

        qb_next  = PW'(pxx_reg) + PW'(pyy_reg);
        qc_next  = PW'(qxx_reg) + PW'(qyy_reg);
        dd3_next = PW'(pd1_reg) - PW'(pd2_reg);

        m1_next = MW'(yb3_reg) * MW'(qc_reg);
        m2_next = MW'(yc3_reg) * MW'(qb_reg);
        m3_next = MW'(xb3_reg) * MW'(qc_reg);
        m4_next = MW'(xc3_reg) * MW'(qb_reg);

        nx_next = NW'(m1_reg) - NW'(m2_reg);
        ny_next = NW'(m3_reg) - NW'(m4_reg);

        abs_nx = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        abs_ny = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        abs_d  = dd5_reg[PW-1] ? PW'(-dd5_reg) : PW'(dd5_reg);
        numx_next = DIVN_W'({abs_nx, {FRAC{1'b0}}}) + DIVN_W'(abs_d);
        numy_next = DIVN_W'({abs_ny, {FRAC{1'b0}}}) + DIVN_W'(abs_d);
        den2_next = {abs_d, 1'b0};
        side_next.pts   = pts5_reg;
        side_next.neg_x = nx_reg[NW-1] ^ dd5_reg[PW-1];
        side_next.neg_y = ny_reg[NW-1] ^ dd5_reg[PW-1];
        side_next.colin = (dd5_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xb1_reg     <= xb1_next;
            yb1_reg     <= yb1_next;
            xc1_reg     <= xc1_next;
            yc1_reg     <= yc1_next;
            pts1_reg.ax <= a_x;
            pts1_reg.ay <= a_y;
            pts1_reg.cx <= c_x;
            pts1_reg.cy <= c_y;

            pxx_reg  <= pxx_next;
            pyy_reg  <= pyy_next;
            qxx_reg  <= qxx_next;
            qyy_reg  <= qyy_next;
            pd1_reg  <= pd1_next;
            pd2_reg  <= pd2_next;
            xb2_reg  <= xb1_reg;
            yb2_reg  <= yb1_reg;
            xc2_reg  <= xc1_reg;
            yc2_reg  <= yc1_reg;
            pts2_reg <= pts1_reg;

            qb_reg   <= qb_next;
            qc_reg   <= qc_next;
            dd3_reg  <= dd3_next;
            xb3_reg  <= xb2_reg;
            yb3_reg  <= yb2_reg;
            xc3_reg  <= xc2_reg;
            yc3_reg  <= yc2_reg;
            pts3_reg <= pts2_reg;

            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            m3_reg   <= m3_next;
            m4_reg   <= m4_next;
            dd4_reg  <= dd3_reg;
            pts4_reg <= pts3_reg;

            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            dd5_reg  <= dd4_reg;
            pts5_reg <= pts4_reg;

            numx_reg <= numx_next;
            numy_reg <= numy_next;
            den2_reg <= den2_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign num_x     = numx_reg;
    assign num_y     = numy_reg;
    assign den2      = den2_reg;
    assign side      = side_reg;

endmodule

[src/cc3p_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two numerators over one divisor.
// Depends on cc3p_pkg.
module cc3p_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [cc3p_pkg::DIVN_W-1:0] num_x,
    input  logic [cc3p_pkg::DIVN_W-1:0] num_y,
    input  logic [cc3p_pkg::DIVD_W-1:0] den,
    input  cc3p_pkg::div_side_t        side_in,
    output logic                       out_valid,
    output logic [cc3p_pkg::DIVN_W-1:0] quo_x,
    output logic [cc3p_pkg::DIVN_W-1:0] quo_y,
    output cc3p_pkg::div_side_t        side_out
);
    import cc3p_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIVN_W-1:0]     qx_reg [DIV_STAGES];
    logic [DIVN_W-1:0]     qy_reg [DIV_STAGES];
    logic [DIVD_W-1:0]     rx_reg [DIV_STAGES];
    logic [DIVD_W-1:0]     ry_reg [DIV_STAGES];
    logic [DIVD_W-1:0]     d_reg  [DIV_STAGES];
    div_side_t             side_reg [DIV_STAGES];

    logic [DIVN_W-1:0]     qx_in [DIV_STAGES];
    logic [DIVN_W-1:0]     qy_in [DIV_STAGES];
    logic [DIVD_W-1:0]     rx_in [DIV_STAGES];
    logic [DIVD_W-1:0]     ry_in [DIV_STAGES];
    logic [DIVD_W-1:0]     d_in  [DIV_STAGES];
    div_side_t             side_in_arr [DIV_STAGES];
    logic [DIVD_W:0]       tx [DIV_STAGES];
    logic [DIVD_W:0]       ty [DIV_STAGES];
    logic                  gx [DIV_STAGES];
    logic                  gy [DIV_STAGES];
    logic [DIVN_W-1:0]     qx_next [DIV_STAGES];
    logic [DIVN_W-1:0]     qy_next [DIV_STAGES];
    logic [DIVD_W-1:0]     rx_next [DIV_STAGES];
    logic [DIVD_W-1:0]     ry_next [DIV_STAGES];

    always_comb begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                qx_in[i]       = num_x;
                qy_in[i]       = num_y;
                rx_in[i]       = '0;
                ry_in[i]       = '0;
                d_in[i]        = den;
                side_in_arr[i] = side_in;
            end else begin
                qx_in[i]       = qx_reg[i-1];
                qy_in[i]       = qy_reg[i-1];
                rx_in[i]       = rx_reg[i-1];
                ry_in[i]       = ry_reg[i-1];
                d_in[i]        = d_reg[i-1];
                side_in_arr[i] = side_reg[i-1];
            end
            tx[i] = {rx_in[i], qx_in[i][DIVN_W-1]};
            ty[i] = {ry_in[i], qy_in[i][DIVN_W-1]};
            gx[i] = (tx[i] >= {1'b0, d_in[i]});
            gy[i] = (ty[i] >= {1'b0, d_in[i]});
            rx_next[i] = gx[i] ? DIVD_W'(tx[i] - {1'b0, d_in[i]}) : tx[i][DIVD_W-1:0];
            ry_next[i] = gy[i] ? DIVD_W'(ty[i] - {1'b0, d_in[i]}) : ty[i][DIVD_W-1:0];
            qx_next[i] = {qx_in[i][DIVN_W-2:0], gx[i]};
            qy_next[i] = {qy_in[i][DIVN_W-2:0], gy[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                qx_reg[i]   <= qx_next[i];
                qy_reg[i]   <= qy_next[i];
                rx_reg[i]   <= rx_next[i];
                ry_reg[i]   <= ry_next[i];
                d_reg[i]    <= d_in[i];
                side_reg[i] <= side_in_arr[i];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quo_x     = qx_reg[DIV_STAGES-1];
    assign quo_y     = qy_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

[src/cc3p_post.sv]
// Post pipeline: signed centre, saturation, offsets to the third point, sum of squares.
// Depends on cc3p_pkg.
module cc3p_post (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [cc3p_pkg::DIVN_W-1:0]  quo_x,
    input  logic [cc3p_pkg::DIVN_W-1:0]  quo_y,
    input  cc3p_pkg::div_side_t         side_in,
    output logic                        out_valid,
    output logic [cc3p_pkg::SQ_IN_W-1:0] sum_sq,
    output logic                        ovf,
    output cc3p_pkg::res_side_t         side_out
);
    import cc3p_pkg::*;

    localparam logic signed [OW-1:0] MAXV = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [OW-1:0] MINV = 64'shFFFF_FFFF_8000_0000;

    logic [POST_STAGES-1:0] vld_reg;

    logic signed [OW-1:0] sqx, sqy, ox_next, oy_next, ox_reg, oy_reg;
    logic signed [CW-1:0] cx1_reg, cy1_reg;
    logic                 colin1_reg;

    logic signed [OW-1:0] dx_reg, dy_reg, dx_next, dy_next;
    res_side_t            rs2_reg, rs2_next, rs3_reg, rs4_reg, rs5_reg;

    logic [OW-1:0]        mx_reg, my_reg, mx_next, my_next;
    logic                 big3_reg, big3_next, big4_reg;

    logic [SQ_IN_W-1:0]   s_reg, t_reg, s_next, t_next;
    logic [SQ_IN_W:0]     sum_full;
    logic [SQ_IN_W-1:0]   sum_reg;
    logic                 ovf_reg;

    always_comb begin
        sqx = side_in.neg_x ? -$signed(OW'(quo_x)) : $signed(OW'(quo_x));
        sqy = side_in.neg_y ? -$signed(OW'(quo_y)) : $signed(OW'(quo_y));
        ox_next = (OW'(side_in.pts.ax) <<< FRAC) - sqx;
        oy_next = (OW'(side_in.pts.ay) <<< FRAC) + sqy;

        rs2_next.sat = 1'b0;
        if (ox_reg > MAXV) begin
            rs2_next.rx  = RW'(MAXV);
            rs2_next.sat = 1'b1;
        end else if (ox_reg < MINV) begin
            rs2_next.rx  = RW'(MINV);
            rs2_next.sat = 1'b1;
        end else begin
            rs2_next.rx  = ox_reg[RW-1:0];
        end
        if (oy_reg > MAXV) begin
            rs2_next.ry  = RW'(MAXV);
            rs2_next.sat = 1'b1;
        end else if (oy_reg < MINV) begin
            rs2_next.ry  = RW'(MINV);
            rs2_next.sat = 1'b1;
        end else begin
            rs2_next.ry  = oy_reg[RW-1:0];
        end
        rs2_next.colin = colin1_reg;
        dx_next = (OW'(cx1_reg) <<< FRAC) - ox_reg;
        dy_next = (OW'(cy1_reg) <<< FRAC) - oy_reg;

        mx_next   = dx_reg[OW-1] ? OW'(-dx_reg) : OW'(dx_reg);
        my_next   = dy_reg[OW-1] ? OW'(-dy_reg) : OW'(dy_reg);
        big3_next = (|mx_next[OW-1:RW]) | (|my_next[OW-1:RW]);

        s_next = SQ_IN_W'(mx_reg[RW-1:0]) * SQ_IN_W'(mx_reg[RW-1:0]);
        t_next = SQ_IN_W'(my_reg[RW-1:0]) * SQ_IN_W'(my_reg[RW-1:0]);

        sum_full = {1'b0, s_reg} + {1'b0, t_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[POST_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            cx1_reg    <= side_in.pts.cx;
            cy1_reg    <= side_in.pts.cy;
            colin1_reg <= side_in.colin;

            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            rs2_reg <= rs2_next;

            mx_reg   <= mx_next;
            my_reg   <= my_next;
            big3_reg <= big3_next;
            rs3_reg  <= rs2_reg;

            s_reg    <= s_next;
            t_reg    <= t_next;
            big4_reg <= big3_reg;
            rs4_reg  <= rs3_reg;

            sum_reg  <= sum_full[SQ_IN_W-1:0];
            ovf_reg  <= big4_reg | sum_full[SQ_IN_W];
            rs5_reg  <= rs4_reg;
        end
    end

    assign out_valid = vld_reg[POST_STAGES-1];
    assign sum_sq    = sum_reg;
    assign ovf       = ovf_reg;
    assign side_out  = rs5_reg;

endmodule

[src/cc3p_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on cc3p_pkg.
module cc3p_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [cc3p_pkg::SQ_IN_W-1:0] value,
    input  logic                        ovf_in,
    input  cc3p_pkg::res_side_t         side_in,
    output logic                        out_valid,
    output logic [cc3p_pkg::ROOT_W-1:0]  root,
    output logic                        ovf_out,
    output cc3p_pkg::res_side_t         side_out
);
    import cc3p_pkg::*;

    logic [SQRT_STAGES-1:0] vld_reg;
    logic [SQ_IN_W-1:0]     v_reg    [SQRT_STAGES];
    logic [ROOT_W-1:0]      root_reg [SQRT_STAGES];
    logic [REM_W-1:0]       rem_reg  [SQRT_STAGES];
    logic                   ovf_reg  [SQRT_STAGES];
    res_side_t              side_reg [SQRT_STAGES];

    logic [SQ_IN_W-1:0]     v_in    [SQRT_STAGES];
    logic [ROOT_W-1:0]      root_in [SQRT_STAGES];
    logic [REM_W-1:0]       rem_in  [SQRT_STAGES];
    logic                   ovf_arr [SQRT_STAGES];
    res_side_t              side_arr [SQRT_STAGES];
    logic [REM_W+1:0]       sh   [SQRT_STAGES];
    logic [REM_W+1:0]       trial [SQRT_STAGES];
    logic                   ge   [SQRT_STAGES];
    logic [REM_W-1:0]       rem_next  [SQRT_STAGES];
    logic [ROOT_W-1:0]      root_next [SQRT_STAGES];

    always_comb begin
        for (int i = 0; i < SQRT_STAGES; i++) begin
            if (i == 0) begin
                v_in[i]     = value;
                root_in[i]  = '0;
                rem_in[i]   = '0;
                ovf_arr[i]  = ovf_in;
                side_arr[i] = side_in;
            end else begin
                v_in[i]     = v_reg[i-1];
                root_in[i]  = root_reg[i-1];
                rem_in[i]   = rem_reg[i-1];
                ovf_arr[i]  = ovf_reg[i-1];
                side_arr[i] = side_reg[i-1];
            end
            sh[i]    = {rem_in[i], v_in[i][SQ_IN_W-1:SQ_IN_W-2]};
            trial[i] = (REM_W+2)'({root_in[i], 2'b01});
            ge[i]    = (sh[i] >= trial[i]);
            rem_next[i]  = ge[i] ? REM_W'(sh[i] - trial[i]) : sh[i][REM_W-1:0];
            root_next[i] = {root_in[i][ROOT_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SQRT_STAGES; i++) begin
                v_reg[i]    <= {v_in[i][SQ_IN_W-3:0], 2'b00};
                root_reg[i] <= root_next[i];
                rem_reg[i]  <= rem_next[i];
                ovf_reg[i]  <= ovf_arr[i];
                side_reg[i] <= side_arr[i];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign root      = root_reg[SQRT_STAGES-1];
    assign ovf_out   = ovf_reg[SQRT_STAGES-1];
    assign side_out  = side_reg[SQRT_STAGES-1];

endmodule

[src/circumcircle_of_three_points_unit.sv]
// Circumcircle unit top level: stream ports, pipeline chain, output register.
// Depends on cc3p_pkg, cc3p_front, cc3p_div, cc3p_post, cc3p_sqrt and the defines header.
//
// Takes one point triple per cycle and returns centre (8 fraction bits, saturated),
// radius (floor of the distance to the third point, 8 fraction bits) and a status code.
// The chain has 6 front stages, 60 divider stages (one quotient bit each),
// 5 post stages, 32 square-root stages (one root bit each) and the output register.
// The pipeline holds as a whole while a result waits on m_tready, and takes a new
// item in the cycle the waiting result leaves.
`include "circumcircle_of_three_points_unit_defines.svh"

module circumcircle_of_three_points_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y (16 bits each)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // centre_x, centre_y, circle_radius (32 bits each)
    output logic [1:0]  m_tuser    // status
);
    import cc3p_pkg::*;

    logic               en;
    logic               front_valid, div_valid, post_valid, sqrt_valid;
    logic [DIVN_W-1:0]  num_x, num_y, quo_x, quo_y;
    logic [DIVD_W-1:0]  den2;
    div_side_t          front_side, div_side;
    logic [SQ_IN_W-1:0] sum_sq;
    logic               post_ovf, sqrt_ovf;
    res_side_t          post_side, sqrt_side;
    logic [ROOT_W-1:0]  root;

    logic               out_valid_reg;
    logic [RW-1:0]      cx_reg, cy_reg, rad_reg, cx_next, cy_next, rad_next;
    status_t            status_reg, status_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cc3p_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .a_x       (s_tdata[15:0]),
        .a_y       (s_tdata[31:16]),
        .b_x       (s_tdata[47:32]),
        .b_y       (s_tdata[63:48]),
        .c_x       (s_tdata[79:64]),
        .c_y       (s_tdata[95:80]),
        .out_valid (front_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den2      (den2),
        .side      (front_side)
    );

    cc3p_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den2),
        .side_in   (front_side),
        .out_valid (div_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .side_out  (div_side)
    );

    cc3p_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .side_in   (div_side),
        .out_valid (post_valid),
        .sum_sq    (sum_sq),
        .ovf       (post_ovf),
        .side_out  (post_side)
    );

    cc3p_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (post_valid),
        .value     (sum_sq),
        .ovf_in    (post_ovf),
        .side_in   (post_side),
        .out_valid (sqrt_valid),
        .root      (root),
        .ovf_out   (sqrt_ovf),
        .side_out  (sqrt_side)
    );

    always_comb begin
        if (sqrt_side.colin) begin
            cx_next     = '0;
            cy_next     = '0;
            rad_next    = '0;
            status_next = ST_COLINEAR;
        end else begin
            cx_next     = sqrt_side.rx;
            cy_next     = sqrt_side.ry;
            rad_next    = sqrt_ovf ? '1 : root;
            status_next = (sqrt_side.sat || sqrt_ovf) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= sqrt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            rad_reg    <= rad_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {rad_reg, cy_reg, cx_reg};
    assign m_tuser  = status_reg;

    `CC3P_ASSERT_IMPL(a_colin_zero, m_tvalid && (m_tuser == ST_COLINEAR), m_tdata == '0, "collinear result carries nonzero data")
    `CC3P_ASSERT_NEXT(a_stall_hold, !en, $stable(front_valid) && $stable(div_valid) && $stable(post_valid) && $stable(sqrt_valid), "pipeline moved during stall")

endmodule
